// File: rtl/tfsc_pkg.sv
package tfsc_pkg;

    // odd taylor coefficients of sin(pi/2 * u), scaled by 2^30
    localparam logic [31:0] POLY_C11 = 32'd3864;
    localparam logic [31:0] POLY_C [0:4] = '{
        32'd172272, 32'd5026995, 32'd85569306, 32'd693598669, 32'd1686629713
    };

    // sine magnitude: 0 .. 2^22, scale 2^22
    localparam int unsigned MAG_BITS = 23;
    // sine unit latency in cycles, phase in to magnitude out
    localparam int unsigned SIN_LAT  = 9;

endpackage

// File: rtl/tfsc_sine.sv
module tfsc_sine #(
    parameter int unsigned ANGLE_BITS = 24
) (
    input  logic                               i_clk,
    input  logic [ANGLE_BITS:0]                i_phase,
    output logic [tfsc_pkg::MAG_BITS-1:0]      o_mag,
    output logic                               o_neg
);
    import tfsc_pkg::*;

    localparam int unsigned PAD = 33 - ANGLE_BITS;

    logic [1:0]          quad;
    logic [32:0]         u_raw;
    logic [32:0]         n_u0;
    logic [63:0]         sq;
    logic [64:0]         sprod;
    logic [32:0]         rnd;
    logic [24:0]         rsh;

    logic [32:0]         r_u   [0:6];
    logic                r_neg [0:7];
    logic [32:0]         r_u2  [1:5];
    logic [31:0]         r_t   [2:6];
    logic [31:0]         r_s;
    logic [MAG_BITS-1:0] r_mag;

    // quadrant fold into a 32-bit fraction of a quarter turn
    assign quad  = i_phase[ANGLE_BITS:ANGLE_BITS-1];
    assign u_raw = {1'b0, i_phase[ANGLE_BITS-2:0], {PAD{1'b0}}};
    assign n_u0  = quad[0] ? (33'h1_0000_0000 - u_raw) : u_raw;

    always_ff @(posedge i_clk) begin
        r_u[0]   <= n_u0;
        r_neg[0] <= quad[1];
    end

    // square of the half fraction
    assign sq = 64'(r_u[0][32:1]) * 64'(r_u[0][32:1]);

    always_ff @(posedge i_clk) begin
        r_u2[1]  <= sq[62:30];
        r_u[1]   <= r_u[0];
        r_neg[1] <= r_neg[0];
    end

    // horner steps, one multiply each
    for (genvar k = 2; k <= 6; k++) begin : g_horner
        logic [31:0] t_in;
        logic [64:0] hp;
        if (k == 2) begin : g_first
            assign t_in = POLY_C11;
        end else begin : g_next
            assign t_in = r_t[k-1];
        end
        assign hp = 65'(r_u2[k-1]) * 65'(t_in);
        always_ff @(posedge i_clk) begin
            r_t[k]   <= POLY_C[k-2] - hp[63:32];
            r_u[k]   <= r_u[k-1];
            r_neg[k] <= r_neg[k-1];
        end
        if (k < 6) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_u2[k] <= r_u2[k-1];
            end
        end
    end

    // final multiply by the fraction
    assign sprod = 65'(r_u[6]) * 65'(r_t[6]);

    always_ff @(posedge i_clk) begin
        r_s      <= sprod[63:32];
        r_neg[7] <= r_neg[6];
    end

    // round to 2^-22 and clamp to one
    assign rnd = {1'b0, r_s} + 33'd128;
    assign rsh = rnd[32:8];

    always_ff @(posedge i_clk) begin
        r_mag <= (rsh > 25'(1 << 22)) ? MAG_BITS'(1 << 22) : rsh[MAG_BITS-1:0];
        o_neg <= r_neg[7];
    end

    assign o_mag = r_mag;

endmodule

// File: rtl/two_face_spherical_to_cartesian.sv
// Two-face spherical to rectangular conversion of a surveyed point.
// Input channel: drive the six face fields with i_start high; an item is
// taken at every rising edge where i_start is high and o_busy is low.
// o_busy is always low, so a new item may enter in every cycle.
// Output channel: o_valid is high for exactly one cycle per item with
// o_east_x, o_north_y and o_up_z, two's complement in 0.1 mm units.
// The path holds 14 register stages; o_valid runs through a valid
// line of equal depth and leaves with the result. Throughput is one
// item per cycle. The stages are made up of those of the sine
// units (nine stages: fold, square, five horner steps, final multiply,
// rounding) plus the input stage, the factor product, the split
// distance multiply, the rounding add and the saturation stage.
// Items leave in the order they arrived.
// The receiver cannot stall: results are shown once and not held.
// Synchronous reset clears the valid line; items in flight are dropped.
// Magnitudes beyond 2^DIST_BITS - 1 saturate.
module two_face_spherical_to_cartesian #(
    parameter int unsigned ANGLE_BITS = 24,
    parameter int unsigned DIST_BITS  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [ANGLE_BITS-1:0]       i_face_one_azimuth,
    input  logic [ANGLE_BITS-1:0]       i_face_one_inclination,
    input  logic [DIST_BITS-1:0]        i_face_one_distance,
    input  logic [ANGLE_BITS-1:0]       i_face_two_azimuth,
    input  logic [ANGLE_BITS-1:0]       i_face_two_inclination,
    input  logic [DIST_BITS-1:0]        i_face_two_distance,
    output logic                        o_valid,
    output logic signed [DIST_BITS:0]   o_east_x,
    output logic signed [DIST_BITS:0]   o_north_y,
    output logic signed [DIST_BITS:0]   o_up_z
);
    import tfsc_pkg::*;

    localparam int unsigned AW  = ANGLE_BITS + 1;
    localparam int unsigned DW  = DIST_BITS + 1;
    localparam int unsigned PW  = DIST_BITS + 47;
    localparam int unsigned LAT = SIN_LAT + 5;

    logic [AW-1:0]       sum_az;
    logic [AW-1:0]       n_az;
    logic [AW-1:0]       n_inc;
    logic [AW-1:0]       r_az;
    logic [AW-1:0]       r_inc;
    logic [DW-1:0]       r_dd [0:SIN_LAT+1];
    logic                r_v  [0:LAT-1];
    logic                accept;

    logic [MAG_BITS-1:0] sa, ca, si, ci;
    logic                nsa, nca, nsi, nci;

    logic [44:0]         r_f   [0:2];
    logic                r_sg1 [0:2];
    logic [DW+22:0]      r_pl  [0:2];
    logic [DW+21:0]      r_ph  [0:2];
    logic                r_sg2 [0:2];
    logic [DW:0]         r_q   [0:2];
    logic                r_sg3 [0:2];
    logic [DW-1:0]       r_out [0:2];

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_v[i] <= 1'b0;
        end else begin
            r_v[0] <= accept;
            for (int i = 1; i < LAT; i++) r_v[i] <= r_v[i-1];
        end
    end

    // face averaging of angles, distance sum
    assign sum_az = AW'(i_face_one_azimuth) + AW'(i_face_two_azimuth);
    assign n_az   = (i_face_one_azimuth < i_face_two_azimuth)
                  ? sum_az - AW'(1 << (ANGLE_BITS - 1))
                  : sum_az + AW'(1 << (ANGLE_BITS - 1));
    assign n_inc  = AW'(i_face_one_inclination) - AW'(i_face_two_inclination)
                  + AW'(1 << ANGLE_BITS);

    // distance delay matches the sine units plus the factor stage
    always_ff @(posedge i_clk) begin
        r_az     <= n_az;
        r_inc    <= n_inc;
        r_dd[0]  <= DW'(i_face_one_distance) + DW'(i_face_two_distance);
        for (int i = 1; i <= SIN_LAT + 1; i++) r_dd[i] <= r_dd[i-1];
    end

    // four sine units, cosine as a quarter turn ahead
    tfsc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_az (
        .i_clk(i_clk), .i_phase(r_az), .o_mag(sa), .o_neg(nsa)
    );
    tfsc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_az (
        .i_clk(i_clk), .i_phase(r_az + AW'(1 << (ANGLE_BITS - 1))),
        .o_mag(ca), .o_neg(nca)
    );
    tfsc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_inc (
        .i_clk(i_clk), .i_phase(r_inc), .o_mag(si), .o_neg(nsi)
    );
    tfsc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_inc (
        .i_clk(i_clk), .i_phase(r_inc + AW'(1 << (ANGLE_BITS - 1))),
        .o_mag(ci), .o_neg(nci)
    );

    // direction factors, scale 2^44
    always_ff @(posedge i_clk) begin
        r_f[0]   <= 45'(46'(sa) * 46'(si));
        r_f[1]   <= 45'(46'(ca) * 46'(si));
        r_f[2]   <= {ci[22:0], 22'd0};
        r_sg1[0] <= nsa ^ nsi;
        r_sg1[1] <= nca ^ nsi;
        r_sg1[2] <= nci;
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [PW-1:0] full;
        logic [DW-1:0] sat;

        // distance times factor, split in two partial products
        always_ff @(posedge i_clk) begin
            r_pl[a]  <= (DW+23)'(r_dd[SIN_LAT+1]) * (DW+23)'(r_f[a][22:0]);
            r_ph[a]  <= (DW+22)'(r_dd[SIN_LAT+1]) * (DW+22)'(r_f[a][44:23]);
            r_sg2[a] <= r_sg1[a];
        end

        // join and round half up at 2^-45
        assign full = PW'(r_pl[a]) + (PW'(r_ph[a]) << 23) + (PW'(1) << 44);

        always_ff @(posedge i_clk) begin
            r_q[a]   <= full[PW-1:45];
            r_sg3[a] <= r_sg2[a];
        end

        // saturate magnitude and apply sign
        assign sat = (r_q[a] > (DW+1)'({DIST_BITS{1'b1}}))
                   ? {1'b0, {DIST_BITS{1'b1}}} : r_q[a][DW-1:0];

        always_ff @(posedge i_clk) begin
            r_out[a] <= r_sg3[a] ? (DW'(0) - sat) : sat;
        end
    end

    assign o_valid   = r_v[LAT-1];
    assign o_east_x  = r_out[0];
    assign o_north_y = r_out[1];
    assign o_up_z    = r_out[2];

    // a result appears only for an item that was accepted
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without matching item");

    // saturation keeps every magnitude below the negative limit
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_east_x != {1'b1, {DIST_BITS{1'b0}}})
                 && (o_north_y != {1'b1, {DIST_BITS{1'b0}}})
                 && (o_up_z != {1'b1, {DIST_BITS{1'b0}}}))
        else $error("saturation failed");

    // zero distances give a zero point
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_face_one_distance == '0 && i_face_two_distance == '0, LAT)
        |-> (o_east_x == '0) && (o_north_y == '0) && (o_up_z == '0))
        else $error("nonzero output for zero distance");

endmodule
